>>> src/xypau_pkg.sv
// shared types, command codes and address adjust function for the xy pixel access unit
// no dependencies
`timescale 1ns / 1ps

package xypau_pkg;

  localparam int VramAddrBitsDef = 16;
  localparam int VramAddrMax     = 20;

  // command codes
  localparam logic [2:0] CMD_XY_READ     = 3'd0;
  localparam logic [2:0] CMD_XY_WRITE    = 3'd1;
  localparam logic [2:0] CMD_DIRECT_READ = 3'd2;
  localparam logic [2:0] CMD_DIRECT_WR   = 3'd3;
  localparam logic [2:0] CMD_XY_LOW      = 3'd4;
  localparam logic [2:0] CMD_XY_HIGH     = 3'd5;
  localparam logic [2:0] CMD_LATCH       = 3'd6;

  // configuration register indexes
  localparam logic [1:0] REG_X_FIELD_BITS = 2'd0;
  localparam logic [1:0] REG_XY_PAGE      = 2'd1;
  localparam logic [1:0] REG_ROW_SHIFT    = 2'd2;

  localparam logic [3:0] XBitsMin      = 4'd2;
  localparam logic [3:0] XBitsMax      = 4'd9;
  localparam logic [3:0] XBitsReset    = 4'd6;
  localparam logic [3:0] RowShiftReset = 4'd8;

  // adjust op codes, one per axis
  localparam logic [1:0] ADJ_NONE = 2'd0;
  localparam logic [1:0] ADJ_INC  = 2'd1;
  localparam logic [1:0] ADJ_DEC  = 2'd2;
  localparam logic [1:0] ADJ_ZERO = 2'd3;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'b00,
    MEM_READ  = 2'b01,
    MEM_WRITE = 2'b10
  } mem_op_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  adjust;
    logic [11:0] row;
    logic [9:0]  col;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] xy_address_now;
  } out_item_t;

  typedef struct packed {
    mem_op_t                op;
    logic [VramAddrMax-1:0] addr;
    logic [7:0]             data;
    logic [7:0]             latch;
    logic [15:0]            xy_now;
  } entry_t;

  function automatic logic [15:0] post_adjust(input logic [15:0] a, input logic [3:0] code,
                                              input logic [3:0] xbits);
    logic [15:0] ystep;
    logic [15:0] xmask;
    logic [15:0] v;
    logic [1:0]  xop;
    logic [1:0]  yop;
    ystep = 16'd1 << xbits;
    xmask = ystep - 16'd1;
    xop   = code[1:0];
    yop   = code[3:2];
    v     = a;
    if (yop == ADJ_NONE) begin
      // x carries or borrows into y
      case (xop)
        ADJ_INC:  v = a + 16'd1;
        ADJ_DEC:  v = a - 16'd1;
        ADJ_ZERO: v = a & ~xmask;
        default:  v = a;
      endcase
    end else begin
      // x wraps inside its field
      case (xop)
        ADJ_INC:  v = (a & ~xmask) | ((a + 16'd1) & xmask);
        ADJ_DEC:  v = (a & ~xmask) | ((a - 16'd1) & xmask);
        ADJ_ZERO: v = a & ~xmask;
        default:  v = a;
      endcase
      case (yop)
        ADJ_INC: v = v + ystep;
        ADJ_DEC: v = v - ystep;
        default: v = v & xmask;
      endcase
    end
    return v;
  endfunction

endpackage

>>> src/xypau_front.sv
// front part: config registers, xy address and latch byte, command decode
// depends on xypau_pkg
`timescale 1ns / 1ps

module xypau_front #(
  parameter int VramAddrBits = xypau_pkg::VramAddrBitsDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  xypau_pkg::in_item_t item,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [3:0]         wr_data,
  input  logic               stall,
  output logic               busy,
  output logic               push,
  output xypau_pkg::entry_t  entry
);

  logic [3:0]  x_field_bits;
  logic [3:0]  xy_page;
  logic [3:0]  row_shift;
  logic [15:0] xy_address;
  logic [15:0] xy_address_next;
  logic [7:0]  latch_byte;

  logic [19:0]             xy_full;
  logic [26:0]             direct_full;
  logic [VramAddrBits-1:0] xy_addr;
  logic [VramAddrBits-1:0] d_addr;
  logic [15:0]             adjusted;

  assign busy = stall;
  assign push = start && !stall;

  assign xy_full     = {xy_page, xy_address};
  assign direct_full = (27'(item.row) << row_shift) | 27'(item.col);
  assign xy_addr     = xy_full[VramAddrBits-1:0];
  assign d_addr      = direct_full[VramAddrBits-1:0];
  assign adjusted    = xypau_pkg::post_adjust(xy_address, item.adjust, x_field_bits);

  always_comb begin
    xy_address_next = xy_address;
    entry.op        = xypau_pkg::MEM_NONE;
    entry.addr      = xypau_pkg::VramAddrMax'(xy_addr);
    entry.data      = item.data;
    entry.latch     = latch_byte;
    case (item.cmd)
      xypau_pkg::CMD_XY_READ: begin
        entry.op        = xypau_pkg::MEM_READ;
        xy_address_next = adjusted;
      end
      xypau_pkg::CMD_XY_WRITE: begin
        entry.op        = xypau_pkg::MEM_WRITE;
        xy_address_next = adjusted;
      end
      xypau_pkg::CMD_DIRECT_READ: begin
        entry.op   = xypau_pkg::MEM_READ;
        entry.addr = xypau_pkg::VramAddrMax'(d_addr);
      end
      xypau_pkg::CMD_DIRECT_WR: begin
        entry.op   = xypau_pkg::MEM_WRITE;
        entry.addr = xypau_pkg::VramAddrMax'(d_addr);
      end
      xypau_pkg::CMD_XY_LOW:  xy_address_next = {xy_address[15:8], item.data};
      xypau_pkg::CMD_XY_HIGH: xy_address_next = {item.data, xy_address[7:0]};
      default: ;
    endcase
    entry.xy_now = xy_address_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_field_bits <= xypau_pkg::XBitsReset;
      xy_page      <= '0;
      row_shift    <= xypau_pkg::RowShiftReset;
      xy_address   <= '0;
      latch_byte   <= '0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          xypau_pkg::REG_X_FIELD_BITS: begin
            // out-of-range widths are dropped
            if (wr_data >= xypau_pkg::XBitsMin && wr_data <= xypau_pkg::XBitsMax) begin
              x_field_bits <= wr_data;
            end
          end
          xypau_pkg::REG_XY_PAGE:   xy_page   <= wr_data;
          xypau_pkg::REG_ROW_SHIFT: row_shift <= wr_data;
          default: ;
        endcase
      end
      if (push) begin
        xy_address <= xy_address_next;
        if (item.cmd == xypau_pkg::CMD_LATCH) begin
          latch_byte <= item.data;
        end
      end
    end
  end

endmodule

>>> src/xypau_fifo.sv
// two-entry queue of memory operations between front and back
// depends on xypau_pkg
`timescale 1ns / 1ps

module xypau_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  xypau_pkg::entry_t push_entry,
  input  logic              pop,
  output logic              empty,
  output logic              full,
  output xypau_pkg::entry_t pop_entry
);

  xypau_pkg::entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign empty     = (count == 2'd0);
  assign full      = (count == 2'd2);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/xypau_back.sv
// back part: pixel and latch memories, clearing pass after reset, result register
// depends on xypau_pkg
`timescale 1ns / 1ps

module xypau_back #(
  parameter int VramAddrBits = xypau_pkg::VramAddrBitsDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pop,
  input  xypau_pkg::entry_t    op_entry,
  output logic                 clearing,
  output logic                 done,
  output xypau_pkg::out_item_t result
);

  localparam int Depth = 2 ** VramAddrBits;

  logic [7:0] pixel_mem [Depth];
  logic [7:0] latch_mem [Depth];

  logic [VramAddrBits-1:0] clr_addr;
  logic [VramAddrBits-1:0] addr;
  logic [7:0]              rdata;
  logic                    rd_flag;
  logic [15:0]             xy_now;

  assign addr = op_entry.addr[VramAddrBits-1:0];

  always_ff @(posedge clk) begin
    if (clearing) begin
      pixel_mem[clr_addr] <= 8'd0;
      latch_mem[clr_addr] <= 8'd0;
    end else if (pop && op_entry.op == xypau_pkg::MEM_WRITE) begin
      pixel_mem[addr] <= op_entry.data;
      latch_mem[addr] <= op_entry.latch;
    end
    rdata <= pixel_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_flag <= (op_entry.op == xypau_pkg::MEM_READ);
      xy_now  <= op_entry.xy_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= pop;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == '1) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  assign result.read_data      = rd_flag ? rdata : 8'd0;
  assign result.xy_address_now = xy_now;

endmodule

>>> src/xy_pixel_access_unit_core.sv
// path: a taken command is queued in the fifo, then popped into the back part's done and result registers
// throughput: one command per cycle while busy is low, one memory access each in the back part
// reset: xy address, latch byte and config return to defaults; both memories are
// then zeroed by a pass over every address during which busy is high
// results are strobed for one cycle; the receiver cannot stall
`timescale 1ns / 1ps

module xy_pixel_access_unit_core #(
  parameter int VRAM_ADDR_BITS = xypau_pkg::VramAddrBitsDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  xypau_pkg::in_item_t  item,
  output logic                 done,
  output xypau_pkg::out_item_t result,
  input  logic                 wr_en,
  input  logic [1:0]           wr_index,
  input  logic [3:0]           wr_data
);

  xypau_pkg::entry_t push_entry;
  xypau_pkg::entry_t pop_entry;
  logic push;
  logic pop;
  logic empty;
  logic full;
  logic clearing;

  assign pop = !empty && !clearing;

  xypau_front #(.VramAddrBits(VRAM_ADDR_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .stall    (clearing || full),
    .busy     (busy),
    .push     (push),
    .entry    (push_entry)
  );

  xypau_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .empty      (empty),
    .full       (full),
    .pop_entry  (pop_entry)
  );

  xypau_back #(.VramAddrBits(VRAM_ADDR_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .pop      (pop),
    .op_entry (pop_entry),
    .clearing (clearing),
    .done     (done),
    .result   (result)
  );

endmodule

>>> src/xypau_checker.sv
// port-level checks on the xy pixel access unit, bound to the top level
// depends on xypau_pkg and xy_pixel_access_unit_core
`timescale 1ns / 1ps

module xypau_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input xypau_pkg::in_item_t  item,
  input logic                 done,
  input xypau_pkg::out_item_t result
);

  // memory clear keeps the block busy right after reset
  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  // every transfer in gives a result strobe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("missing result strobe");

  // no result without a transfer in
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without command");

  // only reads return nonzero data
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.read_data != 8'd0) |->
      $past(item.cmd == xypau_pkg::CMD_XY_READ || item.cmd == xypau_pkg::CMD_DIRECT_READ, 2))
    else $error("nonzero read data on a non-read");

  // low byte load shows up in the reported address
  a_low_load: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd == xypau_pkg::CMD_XY_LOW) |=> ##1
      (result.xy_address_now[7:0] == $past(item.data, 2)))
    else $error("low byte load not reflected");

endmodule

bind xy_pixel_access_unit_core xypau_checker u_xypau_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);

>>> verif/testbench.sv
// testbench for xy_pixel_access_unit_core: directed and random command traffic
// checked against an in-bench model of the xy address, latch and pixel memory
// depends on src/xypau_pkg.sv and src/xy_pixel_access_unit_core.sv
`timescale 1ns / 1ps

module testbench;

  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam logic [1:0] REG_NONE   = 2'd3;
  localparam int         StallLimit = 200000;
  localparam int         SettleCycles = 6;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  xypau_pkg::in_item_t  item = '0;
  logic                 done;
  xypau_pkg::out_item_t result;
  logic       wr_en = 1'b0;
  logic [1:0] wr_index = '0;
  logic [3:0] wr_data = '0;

  // model state
  logic [3:0]  xbits_m = xypau_pkg::XBitsReset;
  logic [3:0]  page_m = '0;
  logic [3:0]  shift_m = xypau_pkg::RowShiftReset;
  logic [15:0] xy_reg = '0;
  logic [7:0]  latch_reg = '0;
  bit   [7:0]  pix_mem [65536];
  bit   [7:0]  latch_mem [65536];

  xypau_pkg::out_item_t pending_results[$];
  int        n_sent = 0;
  int        n_errors = 0;
  int        stall_cycles = 0;
  bit        no_gaps = 1'b0;

  xy_pixel_access_unit_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .done     (done),
    .result   (result),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // post-adjust of the xy address; x is the low xbits_m bits, y the rest
  function automatic logic [15:0] adjust_xy(input logic [15:0] a, input logic [3:0] code);
    logic [15:0] xmask;
    logic [15:0] ystep;
    logic [15:0] x;
    logic [15:0] y;
    ystep = 16'd1 << xbits_m;
    xmask = ystep - 16'd1;
    if (code[3:2] == xypau_pkg::ADJ_NONE) begin
      case (code[1:0])
        xypau_pkg::ADJ_INC:  return a + 16'd1;
        xypau_pkg::ADJ_DEC:  return a - 16'd1;
        xypau_pkg::ADJ_ZERO: return a & ~xmask;
        default:  return a;
      endcase
    end
    x = a & xmask;
    y = a & ~xmask;
    case (code[1:0])
      xypau_pkg::ADJ_INC:  x = (a + 16'd1) & xmask;
      xypau_pkg::ADJ_DEC:  x = (a - 16'd1) & xmask;
      xypau_pkg::ADJ_ZERO: x = '0;
      default:  ;
    endcase
    case (code[3:2])
      xypau_pkg::ADJ_INC: y = y + ystep;
      xypau_pkg::ADJ_DEC: y = y - ystep;
      default: y = '0;
    endcase
    return y | x;
  endfunction

  function automatic xypau_pkg::out_item_t predict_access(input xypau_pkg::in_item_t it);
    xypau_pkg::out_item_t r;
    logic [31:0] wide;
    logic [15:0] xa;
    logic [15:0] da;
    r.read_data = '0;
    // page bits land above the 16-bit memory and drop out
    xa = xy_reg;
    wide = (32'(it.row) << shift_m) | 32'(it.col);
    da = wide[15:0];
    case (it.cmd)
      xypau_pkg::CMD_XY_READ: begin
        r.read_data = pix_mem[xa];
        xy_reg = adjust_xy(xy_reg, it.adjust);
      end
      xypau_pkg::CMD_XY_WRITE: begin
        pix_mem[xa] = it.data;
        latch_mem[xa] = latch_reg;
        xy_reg = adjust_xy(xy_reg, it.adjust);
      end
      xypau_pkg::CMD_DIRECT_READ: r.read_data = pix_mem[da];
      xypau_pkg::CMD_DIRECT_WR: begin
        pix_mem[da] = it.data;
        latch_mem[da] = latch_reg;
      end
      xypau_pkg::CMD_XY_LOW:  xy_reg[7:0] = it.data;
      xypau_pkg::CMD_XY_HIGH: xy_reg[15:8] = it.data;
      xypau_pkg::CMD_LATCH:   latch_reg = it.data;
      default: ;
    endcase
    r.xy_address_now = xy_reg;
    return r;
  endfunction

  function automatic xypau_pkg::in_item_t mk(input logic [2:0] c, input logic [3:0] adj,
                                             input logic [11:0] r, input logic [9:0] cl,
                                             input logic [7:0] d);
    xypau_pkg::in_item_t it;
    it.cmd = c;
    it.adjust = adj;
    it.row = r;
    it.col = cl;
    it.data = d;
    return it;
  endfunction

  // result checking and stall watchdog
  always @(posedge clk) begin
    xypau_pkg::out_item_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no transfer pending: read_data %0h xy_address_now %0h",
               result.read_data, result.xy_address_now);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (result.read_data !== want.read_data) begin
          $error("read_data: expected %0h, actual %0h", want.read_data, result.read_data);
          n_errors++;
        end
        if (result.xy_address_now !== want.xy_address_now) begin
          $error("xy_address_now: expected %0h, actual %0h",
                 want.xy_address_now, result.xy_address_now);
          n_errors++;
        end
      end
    end
    if ((start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // start stays high on return so back-to-back transfers need no extra edge
  task automatic send(input xypau_pkg::in_item_t it);
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_access(it));
    n_sent++;
  endtask

  task automatic gap();
    int n;
    int r;
    if (no_gaps) return;
    r = $urandom_range(0, 99);
    if (r < 65) n = 0;
    else if (r < 93) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_gap(input xypau_pkg::in_item_t it);
    send(it);
    gap();
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // wr_en is left high; callers lower it after the last write
  task automatic reg_write(input logic [1:0] idx, input logic [3:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    case (idx)
      xypau_pkg::REG_X_FIELD_BITS:
        if (val >= xypau_pkg::XBitsMin && val <= xypau_pkg::XBitsMax) xbits_m = val;
      xypau_pkg::REG_XY_PAGE:      page_m = val;
      xypau_pkg::REG_ROW_SHIFT:    shift_m = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [3:0] xb, input logic [3:0] pg, input logic [3:0] sh);
    drain();
    reg_write(xypau_pkg::REG_X_FIELD_BITS, xb);
    reg_write(xypau_pkg::REG_XY_PAGE, pg);
    reg_write(xypau_pkg::REG_ROW_SHIFT, sh);
    wr_en <= 1'b0;
  endtask

  task automatic load_xy(input logic [15:0] a);
    send_gap(mk(xypau_pkg::CMD_XY_LOW, 4'($urandom), 12'($urandom), 10'($urandom), a[7:0]));
    send_gap(mk(xypau_pkg::CMD_XY_HIGH, 4'($urandom), 12'($urandom), 10'($urandom), a[15:8]));
  endtask

  // write a run of pixels with one adjust code, then read the run back
  task automatic xy_run();
    logic [15:0] base;
    logic [3:0]  adj;
    int          n;
    base = {($urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 3))), 8'($urandom)};
    adj = 4'($urandom_range(0, 15));
    n = $urandom_range(2, 8);
    if ($urandom_range(0, 3) == 0)
      send_gap(mk(xypau_pkg::CMD_LATCH, 4'($urandom), 12'($urandom), 10'($urandom),
                  8'($urandom)));
    load_xy(base);
    repeat (n) send_gap(mk(xypau_pkg::CMD_XY_WRITE, adj, 12'($urandom), 10'($urandom),
                           8'($urandom)));
    load_xy(base);
    repeat (n) send_gap(mk(xypau_pkg::CMD_XY_READ, adj, 12'($urandom), 10'($urandom),
                           8'($urandom)));
  endtask

  task automatic direct_pair();
    logic [11:0] r;
    logic [9:0]  c;
    r = $urandom_range(0, 1) ? 12'($urandom) : 12'($urandom_range(0, 3));
    c = $urandom_range(0, 1) ? 10'($urandom) : 10'($urandom_range(0, 15));
    send_gap(mk(xypau_pkg::CMD_DIRECT_WR, 4'($urandom), r, c, 8'($urandom)));
    if ($urandom_range(0, 1))
      send_gap(mk(xypau_pkg::CMD_XY_READ, 4'($urandom), 12'($urandom), 10'($urandom),
                  8'($urandom)));
    send_gap(mk(xypau_pkg::CMD_DIRECT_READ, 4'($urandom), r, c, 8'($urandom)));
  endtask

  task automatic random_single();
    logic [2:0] c;
    int         w;
    w = $urandom_range(0, 99);
    if (w < 25) c = xypau_pkg::CMD_XY_READ;
    else if (w < 50) c = xypau_pkg::CMD_XY_WRITE;
    else if (w < 62) c = xypau_pkg::CMD_DIRECT_READ;
    else if (w < 74) c = xypau_pkg::CMD_DIRECT_WR;
    else if (w < 82) c = xypau_pkg::CMD_XY_LOW;
    else if (w < 88) c = xypau_pkg::CMD_XY_HIGH;
    else if (w < 96) c = xypau_pkg::CMD_LATCH;
    else c = CMD_UNUSED;
    send_gap(mk(c, 4'($urandom),
                $urandom_range(0, 1) ? 12'($urandom) : 12'($urandom_range(0, 3)),
                $urandom_range(0, 1) ? 10'($urandom) : 10'($urandom_range(0, 15)),
                8'($urandom)));
  endtask

  task automatic run_random(input int n);
    int target;
    int w;
    target = n_sent + n;
    while (n_sent < target) begin
      // occasional stretches with back-to-back transfers
      if ($urandom_range(0, 19) == 0) no_gaps = !no_gaps;
      w = $urandom_range(0, 9);
      if (w < 6) xy_run();
      else if (w < 8) direct_pair();
      else random_single();
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_directed();
    // reset values, x field 6 bits; read of cleared memory first
    send(mk(xypau_pkg::CMD_XY_READ, {xypau_pkg::ADJ_NONE, xypau_pkg::ADJ_NONE}, '0, '0, '0));
    send(mk(xypau_pkg::CMD_LATCH, '0, '0, '0, 8'hA5));
    send(mk(xypau_pkg::CMD_XY_LOW, '0, '0, '0, 8'hFF));
    send(mk(xypau_pkg::CMD_XY_HIGH, '0, '0, '0, 8'hFF));
    // x carry out of the top of the register, then borrow back
    send(mk(xypau_pkg::CMD_XY_WRITE, {xypau_pkg::ADJ_NONE, xypau_pkg::ADJ_INC}, '0, '0, 8'hFF));
    send(mk(xypau_pkg::CMD_XY_WRITE, {xypau_pkg::ADJ_NONE, xypau_pkg::ADJ_DEC}, '0, '0, 8'h00));
    send(mk(xypau_pkg::CMD_XY_READ, {xypau_pkg::ADJ_NONE, xypau_pkg::ADJ_ZERO}, '0, '0, '0));
    for (int i = 4; i < 16; i++) begin
      send(mk(xypau_pkg::CMD_XY_READ, 4'(i), '0, '0, 8'($urandom)));
      gap();
    end
    send(mk(xypau_pkg::CMD_DIRECT_WR, 4'hF, 12'hFFF, 10'h3FF, 8'h5A));
    send(mk(xypau_pkg::CMD_DIRECT_READ, '0, 12'hFFF, 10'h3FF, '0));
    send(mk(xypau_pkg::CMD_DIRECT_READ, '0, '0, '0, '0));
    send(mk(CMD_UNUSED, 4'hF, 12'hFFF, 10'h3FF, 8'hFF));
    drain();
  endtask

  task automatic test_x_width_min();
    configure(xypau_pkg::XBitsMin, 4'hF, 4'd0);
    run_random(300);
  endtask

  task automatic test_x_width_max();
    configure(xypau_pkg::XBitsMax, 4'h0, 4'd10);
    run_random(300);
  endtask

  task automatic test_large_row_shift();
    configure(4'd5, 4'h5, 4'd11);
    run_random(200);
    configure(4'd7, 4'hA, 4'd15);
    run_random(200);
  endtask

  task automatic test_ignored_writes();
    configure(4'd4, 4'h3, 4'd8);
    @(posedge clk);
    // out-of-range x widths and the unused register index leave config alone
    reg_write(xypau_pkg::REG_X_FIELD_BITS, 4'd0);
    reg_write(xypau_pkg::REG_X_FIELD_BITS, 4'd1);
    reg_write(xypau_pkg::REG_X_FIELD_BITS, 4'd10);
    reg_write(xypau_pkg::REG_X_FIELD_BITS, 4'd15);
    reg_write(REG_NONE, 4'($urandom));
    wr_en <= 1'b0;
    run_random(150);
  endtask

  task automatic test_random_config();
    repeat (4) begin
      configure(4'($urandom_range(2, 9)), 4'($urandom_range(0, 15)),
                4'($urandom_range(0, 15)));
      run_random(200);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    // memory clear pass must be over before config writes
    while (busy) @(posedge clk);
    test_x_width_min();
    test_x_width_max();
    test_large_row_shift();
    test_ignored_writes();
    test_random_config();
    drain();
    if (n_errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> xy_pixel_access_unit_core.f
src/xypau_pkg.sv
src/xypau_front.sv
src/xypau_fifo.sv
src/xypau_back.sv
src/xy_pixel_access_unit_core.sv
src/xypau_checker.sv
verif/testbench.sv
